FILE: rtl/core/lpg_pkg.sv
package lpg_pkg;

    typedef enum logic [1:0] {
        WALK_IDLE    = 2'd0,
        WALK_ROW     = 2'd1,
        WALK_COLUMN  = 2'd2,
        WALK_GENERAL = 2'd3
    } walk_mode_t;

    typedef enum logic [2:0] {
        BE_IDLE  = 3'd0,
        BE_SQRT  = 3'd1,
        BE_DIVX  = 3'd2,
        BE_DIVY  = 3'd3,
        BE_EMIT  = 3'd4
    } back_state_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

FILE: rtl/core/lpg_front.sv
module lpg_front
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 13
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_op,
    input  logic [4*COORD_BITS+23:0]  in_data,
    output logic                      q_valid,
    input  logic                      q_ready,
    output logic                      q_op,
    output logic [4*COORD_BITS+23:0]  q_data
);

    // two-entry queue between front and back
    logic [1:0]                     cnt_reg, cnt_next;
    logic                           rd_reg, rd_next;
    logic                           wr_reg, wr_next;
    logic                           op_reg [2];
    logic [4*COORD_BITS+23:0]       data_reg [2];
    logic                           push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_op     = op_reg[rd_reg];
    assign q_data   = data_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_reg]   <= in_op;
            data_reg[wr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/core/lpg_back.sv
module lpg_back
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  logic                      q_op,
    input  logic [4*COORD_BITS+23:0]  q_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*COORD_BITS+23:0]  out_data,
    output logic                      out_user,
    output logic                      out_last
);

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int PW  = CB + FB + 1;           // position width
    localparam int SW  = FB + 2;                // step width
    localparam int DW  = CB + 1;                // difference width
    localparam int QW  = 2 * DW;                // sum of squares width
    localparam int RW  = CB + FB + 2;           // root width
    localparam int RMW = RW + 2;                // sqrt remainder width
    localparam int SQ_ITER = CB + FB + 1;
    localparam int DV_ITER = CB + 2 * FB;
    localparam int NUMW = CB + 2 * FB;
    localparam int DRW  = RW + 1;
    localparam int CTW  = $clog2(DV_ITER + 1);
    localparam int RTW  = RW - FB;              // integer part of the root
    localparam int RSQW = 2 * RTW;

    back_state_t            state_reg, state_next;
    walk_mode_t             mode_reg;
    logic [DW:0]            left_reg;
    logic signed [PW-1:0]   posx_reg, posy_reg;
    logic signed [SW-1:0]   stepx_reg, stepy_reg;
    logic [23:0]            color_reg;
    logic                   ovalid_reg;
    logic [2*CB+23:0]       odata_reg;
    logic                   olast_reg;
    logic                   pvalid_reg;

    // iterative unit state
    logic [QW-1:0]          s_reg;
    logic [RMW-1:0]         rem_reg;
    logic [RW-1:0]          root_reg;
    logic [CTW-1:0]         cnt_reg;
    logic [NUMW-1:0]        num_reg;
    logic [DRW-1:0]         drem_reg;
    logic [NUMW-1:0]        quo_reg;
    logic signed [DW-1:0]   dx_reg, dy_reg;

    logic signed [CB-1:0]   ax, ay, bx, by;
    logic signed [DW-1:0]   dx, dy;
    logic [DW-1:0]          adx, ady;
    logic                   out_free;
    logic                   take;

    assign ax = q_data[CB-1:0];
    assign ay = q_data[2*CB-1:CB];
    assign bx = q_data[3*CB-1:2*CB];
    assign by = q_data[4*CB-1:3*CB];
    assign dx = DW'(ax) - DW'(bx);
    assign dy = DW'(ay) - DW'(by);
    assign adx = dx[DW-1] ? DW'(-dx) : dx;
    assign ady = dy[DW-1] ? DW'(-dy) : dy;

    assign out_free  = !ovalid_reg || out_ready;
    assign q_ready   = (state_reg == BE_IDLE) && out_free;
    assign take      = q_valid && q_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_user  = pvalid_reg;
    assign out_last  = olast_reg;

    // sqrt step
    logic [1:0]       pair;
    logic [RMW-1:0]   srem, strial;
    logic             sfit;
    logic [CTW-1:0]   k;
    always_comb
    begin
        k = cnt_reg;
        pair = (k >= CTW'(FB)) ? 2'(s_reg >> (2 * (32'(k) - FB))) : 2'b00;
        srem = {rem_reg[RMW-3:0], pair};
        strial = {root_reg[RW-1:0], 2'b01};
        sfit = srem >= strial;
    end

    // division step
    logic [DRW-1:0]   drem;
    logic             dfit;
    always_comb
    begin
        drem = {drem_reg[DRW-2:0], num_reg[NUMW-1]};
        dfit = drem >= DRW'(root_reg);
    end

    logic [DW:0]            len;
    logic [RTW-1:0]         r;
    logic [RSQW-1:0]        rsq;
    always_comb
    begin
        r   = root_reg[RW-1:FB];
        rsq = RSQW'(r) * RSQW'(r);
        len = (DW+1)'(r) + ((rsq != RSQW'(s_reg)) ? (DW+1)'(1) : '0);
    end

    function automatic logic [CB-1:0] trunc_pos(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        begin
            q = p[PW-1] ? PW'(-((-p) >>> FB)) : PW'(p >>> FB);
            trunc_pos = q[CB-1:0];
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE:
                if (take && q_op == OP_START && dx != '0 && dy != '0)
                    state_next = BE_SQRT;
            BE_SQRT:
                if (cnt_reg == '0)
                    state_next = BE_DIVX;
            BE_DIVX:
                if (cnt_reg == '0)
                    state_next = BE_DIVY;
            BE_DIVY:
                if (cnt_reg == '0)
                    state_next = BE_EMIT;
            BE_EMIT:
                if (out_free)
                    state_next = BE_IDLE;
            default:
                state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BE_IDLE;
            mode_reg   <= WALK_IDLE;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
            olast_reg  <= 1'b0;
            pvalid_reg <= 1'b0;
            posx_reg   <= '0;
            posy_reg   <= '0;
            stepx_reg  <= '0;
            stepy_reg  <= '0;
            color_reg  <= '0;
            s_reg      <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
            cnt_reg    <= '0;
            num_reg    <= '0;
            drem_reg   <= '0;
            quo_reg    <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                if (q_op == OP_START)
                begin
                    color_reg <= q_data[4*CB+23:4*CB];
                    if (dy == '0 && dx == '0)
                    begin
                        // empty line
                        ovalid_reg <= 1'b1;
                        pvalid_reg <= 1'b0;
                        odata_reg  <= '0;
                        olast_reg  <= 1'b0;
                        mode_reg   <= WALK_IDLE;
                        left_reg   <= '0;
                    end
                    else if (dy == '0)
                    begin
                        ovalid_reg <= 1'b1;
                        pvalid_reg <= 1'b1;
                        odata_reg  <= {q_data[4*CB+23:4*CB], by, dx[DW-1] ? ax : bx};
                        olast_reg  <= (adx == DW'(1));
                        mode_reg   <= (adx == DW'(1)) ? WALK_IDLE : WALK_ROW;
                        posx_reg   <= (PW'(dx[DW-1] ? ax : bx) <<< FB) + (PW'(1) <<< FB);
                        posy_reg   <= PW'(by) <<< FB;
                        stepx_reg  <= SW'(1) <<< FB;
                        stepy_reg  <= '0;
                        left_reg   <= (DW+1)'(adx) - 1'b1;
                    end
                    else if (dx == '0)
                    begin
                        ovalid_reg <= 1'b1;
                        pvalid_reg <= 1'b1;
                        odata_reg  <= {q_data[4*CB+23:4*CB], dy[DW-1] ? ay : by, bx};
                        olast_reg  <= (ady == DW'(1));
                        mode_reg   <= (ady == DW'(1)) ? WALK_IDLE : WALK_COLUMN;
                        posx_reg   <= PW'(bx) <<< FB;
                        posy_reg   <= (PW'(dy[DW-1] ? ay : by) <<< FB) + (PW'(1) <<< FB);
                        stepx_reg  <= '0;
                        stepy_reg  <= SW'(1) <<< FB;
                        left_reg   <= (DW+1)'(ady) - 1'b1;
                    end
                    else
                    begin
                        // any held word leaves now, the first pixel comes from the emit state
                        ovalid_reg <= 1'b0;
                        mode_reg   <= WALK_GENERAL;
                        posx_reg   <= PW'(bx) <<< FB;
                        posy_reg   <= PW'(by) <<< FB;
                        dx_reg     <= dx;
                        dy_reg     <= dy;
                        s_reg      <= QW'(adx) * QW'(adx) + QW'(ady) * QW'(ady);
                        rem_reg    <= '0;
                        root_reg   <= '0;
                        cnt_reg    <= CTW'(SQ_ITER - 1);
                    end
                end
                else if (left_reg != '0)
                begin
                    ovalid_reg <= 1'b1;
                    pvalid_reg <= 1'b1;
                    odata_reg  <= {color_reg, trunc_pos(posy_reg), trunc_pos(posx_reg)};
                    olast_reg  <= (left_reg == (DW+1)'(1));
                    left_reg   <= left_reg - 1'b1;
                    posx_reg   <= posx_reg + PW'(stepx_reg);
                    posy_reg   <= posy_reg + PW'(stepy_reg);
                    mode_reg   <= (left_reg == (DW+1)'(1)) ? WALK_IDLE : mode_reg;
                end
                else
                begin
                    ovalid_reg <= 1'b1;
                    pvalid_reg <= 1'b0;
                    odata_reg  <= '0;
                    olast_reg  <= 1'b0;
                end
            end
            else
            begin
                if (state_reg == BE_EMIT && out_free)
                begin
                    // first pixel sits at B, steps are ready now
                    ovalid_reg <= 1'b1;
                    pvalid_reg <= 1'b1;
                    odata_reg  <= {color_reg, trunc_pos(posy_reg), trunc_pos(posx_reg)};
                    olast_reg  <= (len == (DW+1)'(1));
                    left_reg   <= len - 1'b1;
                    posx_reg   <= posx_reg + PW'(stepx_reg);
                    posy_reg   <= posy_reg + PW'(stepy_reg);
                    mode_reg   <= (len == (DW+1)'(1)) ? WALK_IDLE : mode_reg;
                end
                else if (ovalid_reg && out_ready)
                    ovalid_reg <= 1'b0;

                unique case (state_reg)
                    BE_SQRT:
                    begin
                        rem_reg  <= sfit ? srem - strial : srem;
                        root_reg <= {root_reg[RW-2:0], sfit};
                        if (cnt_reg == '0)
                        begin
                            num_reg  <= NUMW'(dx_reg[DW-1] ? -dx_reg : dx_reg) << (2*FB);
                            drem_reg <= '0;
                            quo_reg  <= '0;
                            cnt_reg  <= CTW'(DV_ITER - 1);
                        end
                        else
                            cnt_reg <= cnt_reg - 1'b1;
                    end
                    BE_DIVX, BE_DIVY:
                    begin
                        if (cnt_reg == '0 && state_reg == BE_DIVX)
                        begin
                            stepx_reg <= dx_reg[DW-1] ? -SW'({quo_reg[NUMW-2:0], dfit})
                                                      : SW'({quo_reg[NUMW-2:0], dfit});
                            num_reg  <= NUMW'(dy_reg[DW-1] ? -dy_reg : dy_reg) << (2*FB);
                            drem_reg <= '0;
                            quo_reg  <= '0;
                            cnt_reg  <= CTW'(DV_ITER - 1);
                        end
                        else
                        begin
                            drem_reg <= dfit ? drem - DRW'(root_reg) : drem;
                            quo_reg  <= {quo_reg[NUMW-2:0], dfit};
                            num_reg  <= num_reg << 1;
                            cnt_reg  <= cnt_reg - 1'b1;
                            if (cnt_reg == '0)
                                stepy_reg <= dy_reg[DW-1] ? -SW'({quo_reg[NUMW-2:0], dfit})
                                                          : SW'({quo_reg[NUMW-2:0], dfit});
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BE_IDLE) |-> !q_ready)
        else $error("back took an item while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |=> ovalid_reg && $stable(odata_reg))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BE_IDLE) |-> ((mode_reg == WALK_IDLE) == (left_reg == '0)))
        else $error("walk mode and pixel count disagree");

endmodule

FILE: rtl/core/line_pixel_generator.sv
// line pixel generator: dda line rasterizer, one pixel per word
// s_axis: tuser = operation (0 start, 1 next pixel), tdata = endpoints and color
// m_axis: one result word per input word; tuser = pixel_valid, tlast = last pixel
// a start word with a shared x or y gives its first pixel through the
// two-entry input queue and the output register; a general start runs the square
// root and two long divisions in the back end, one bit per cycle, before the
// emit state gives its first pixel
// step words give one result per cycle while the output register drains
// an idle step, or a start with equal endpoints, gives a word with pixel_valid 0
// and all other fields 0
// reset clears the queue, the walk and the output register
// a stalled receiver holds the output word; the queue then fills and
// s_axis_tready drops after two more words
module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // first_x, first_y, second_x, second_y, color_red, color_green, color_blue
    input  logic [((4*COORD_BITS+24+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue
    output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_axis_tdata,
    // pixel_valid
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int IW = 4*COORD_BITS + 24;
    localparam int OW = 2*COORD_BITS + 24;

    logic           q_valid, q_ready, q_op;
    logic [IW-1:0]  q_data;
    logic [OW-1:0]  odata;
    logic           ouser;
    logic           olast;

    lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_data  (s_axis_tdata[IW-1:0]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_op     (q_op),
        .q_data   (q_data)
    );

    lpg_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_op      (q_op),
        .q_data    (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (odata),
        .out_user  (ouser),
        .out_last  (olast)
    );

    assign m_axis_tdata = {{(((OW+7)/8)*8-OW){1'b0}}, odata};
    assign m_axis_tuser = ouser;
    assign m_axis_tlast = olast;

endmodule
